>>> design/utf8d_pkg.sv
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 27;
  localparam int unsigned CntW  = 16;
  localparam int unsigned PendW = 3;

  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

  typedef enum logic [2:0] {
    LeadAscii,
    LeadTwo,
    LeadThree,
    LeadFour,
    LeadFive
  } lead_e;

  function automatic lead_e lead_class(input logic [ByteW-1:0] b);
    lead_e cls;
    if (b inside {[8'h00:8'h7F]}) begin
      cls = LeadAscii;
    end else if (b inside {[8'hC0:8'hDF]}) begin
      cls = LeadTwo;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      cls = LeadThree;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      cls = LeadFour;
    end else begin
      cls = LeadFive;
    end
    return cls;
  endfunction

  // Places the six payload bits of a continuation byte according to the
  // number of continuation bytes still expected before it is taken.
  function automatic logic [CpW-1:0] cont_bits(input logic [PendW-1:0] pend,
                                               input logic [ByteW-1:0] b);
    logic [CpW-1:0] bits;
    bits = CpW'(b[5:0]);
    case (pend)
      3'd2:    cont_bits = bits << 6;
      3'd3:    cont_bits = bits << 12;
      3'd4:    cont_bits = bits << 18;
      default: cont_bits = bits;
    endcase
  endfunction

endpackage

>>> design/utf8_to_code_point_decoder.sv
`timescale 1ns / 1ps

// UTF-8 byte stream to code point decoder.
// The input channel carries one byte of a string per transaction, with
// last_i marking the final byte. The output channel carries one result per
// completed code point and one for the final byte of each string, which
// reports done_res, truncated and limit_hit. Bytes that neither complete a
// code point nor end the string produce no output transaction.
// The max_chars register is written through cfg_we_i and cfg_wdata_i; the
// user must do so only while the block is idle, which the block itself does
// not enforce. Zero means no limit on code points per string.
// A byte goes into an input register on acceptance and is decoded from
// there into the output register whenever the output can advance. One byte
// is taken every cycle while in_stall_o is low: the decode state feeds
// back through masking, shifting, a 16-bit increment and two 16-bit
// compares. When the receiver stalls, the result holds in the output
// register, the pending byte holds in the input register, and in_stall_o
// rises only once both are full. Reset clears the decode state, max_chars
// and both valid flags; the block accepts bytes as soon as reset is released.
module utf8_to_code_point_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [utf8d_pkg::CntW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [utf8d_pkg::ByteW-1:0]   data_byte_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [utf8d_pkg::CpW-1:0]     code_point_o,
  output logic                          has_char_o,
  output logic [utf8d_pkg::CntW-1:0]    char_count_o,
  output logic                          done_res_o,
  output logic                          truncated_o,
  output logic                          limit_hit_o
);
  import utf8d_pkg::*;

  logic [CntW-1:0]  max_chars_q;

  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  logic [PendW-1:0] pend_q, pend_d;
  logic [CpW-1:0]   part_q, part_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             stopped_q, stopped_d;

  logic             out_vld_q, out_vld_d;
  logic [CpW-1:0]   out_cp_q;
  logic             out_has_q;
  logic [CntW-1:0]  out_cnt_q;
  logic             out_done_q;
  logic             out_trunc_q;
  logic             out_limit_q;

  logic             adv;
  logic             proc;
  logic             in_acc;
  logic             stop_pre;
  logic             got;
  logic [PendW-1:0] pend_new;
  logic [CpW-1:0]   part_new;
  logic [CpW-1:0]   cp_new;
  logic [CntW-1:0]  cnt_new;
  logic             stop_post;
  logic             trunc;
  logic             emit;
  lead_e            cls;

  assign adv        = !out_vld_q || !out_stall_i;
  assign proc       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_acc || (in_vld_q && !adv);

  assign cls = lead_class(in_byte_q);

  always_comb begin
    stop_pre = stopped_q || ((max_chars_q != '0) && (pend_q == '0) && (cnt_q >= max_chars_q));
    got      = 1'b0;
    pend_new = pend_q;
    part_new = part_q;
    cp_new   = '0;
    if (!stop_pre) begin
      if (pend_q == '0) begin
        case (cls)
          LeadAscii: begin
            cp_new = CpW'(in_byte_q);
            got    = 1'b1;
          end
          LeadTwo: begin
            part_new = CpW'(in_byte_q[5:0]) << 6;
            pend_new = 3'd1;
          end
          LeadThree: begin
            part_new = CpW'(in_byte_q[4:0]) << 12;
            pend_new = 3'd2;
          end
          LeadFour: begin
            part_new = CpW'(in_byte_q[3:0]) << 18;
            pend_new = 3'd3;
          end
          default: begin
            part_new = CpW'(in_byte_q[2:0]) << 24;
            pend_new = 3'd4;
          end
        endcase
      end else begin
        pend_new = pend_q - 3'd1;
        part_new = part_q | cont_bits(pend_q, in_byte_q);
        if (pend_new == '0) begin
          cp_new   = part_new;
          part_new = '0;
          got      = 1'b1;
        end
      end
    end
    cnt_new   = (got && (cnt_q != CountMax)) ? cnt_q + 16'd1 : cnt_q;
    stop_post = stop_pre || (got && (max_chars_q != '0) && (cnt_new >= max_chars_q));
    trunc     = !stop_pre && in_last_q && (pend_new != '0);
    emit      = got || in_last_q;
  end

  always_comb begin
    pend_d    = pend_q;
    part_d    = part_q;
    cnt_d     = cnt_q;
    stopped_d = stopped_q;
    if (proc) begin
      if (in_last_q) begin
        pend_d    = '0;
        part_d    = '0;
        cnt_d     = '0;
        stopped_d = 1'b0;
      end else begin
        pend_d    = pend_new;
        part_d    = part_new;
        cnt_d     = cnt_new;
        stopped_d = stop_post;
      end
    end
  end

  assign out_vld_d = (proc && emit) || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= '0;
      in_vld_q    <= 1'b0;
      pend_q      <= '0;
      part_q      <= '0;
      cnt_q       <= '0;
      stopped_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_chars_q <= cfg_wdata_i;
      end
      in_vld_q  <= in_vld_d;
      pend_q    <= pend_d;
      part_q    <= part_d;
      cnt_q     <= cnt_d;
      stopped_q <= stopped_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_i;
    end
    if (proc && emit) begin
      out_cp_q    <= cp_new;
      out_has_q   <= got;
      out_cnt_q   <= cnt_new;
      out_done_q  <= in_last_q;
      out_trunc_q <= trunc;
      out_limit_q <= stop_post;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign code_point_o = out_cp_q;
  assign has_char_o   = out_has_q;
  assign char_count_o = out_cnt_q;
  assign done_res_o   = out_done_q;
  assign truncated_o  = out_trunc_q;
  assign limit_hit_o  = out_limit_q;

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("pending continuation count out of range");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_last_q) |=> (pend_q == '0) && (cnt_q == '0) && !stopped_q && (part_q == '0))
    else $error("string state not cleared after final byte");

  a_no_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_has_q) |-> (out_cp_q == '0))
    else $error("code point nonzero on a result without a character");

  a_trunc_limit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_trunc_q && out_limit_q))
    else $error("truncated and limit_hit reported together");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_vld_q && out_stall_i && in_vld_q))
    else $error("input stalled without a blocked output");

endmodule
